// ===== hdl/graph_bfs_dfs_traversal_assert.svh =====
// assertion macros for the graph traversal block
// used by the port checker; no other dependencies
`ifndef GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH

// same-cycle implication, disabled in reset
`define GBT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("graph traversal check failed");

// next-cycle implication, disabled in reset
`define GBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("graph traversal check failed");

`endif

// ===== hdl/gbt_pkg.sv =====
// shared types and constants for the graph traversal block
// no dependencies
package gbt_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int MAX_ARCS     = 256;
  localparam int VERTEX_W     = $clog2(MAX_VERTICES);
  localparam int LIVE_W       = VERTEX_W + 1;
  localparam int ARC_ADDR_W   = $clog2(MAX_ARCS);
  localparam int ARC_PTR_W    = ARC_ADDR_W + 1;
  localparam int ARC_WORD_W   = VERTEX_W + ARC_PTR_W;
  localparam logic [ARC_PTR_W-1:0] NO_ARC = ARC_PTR_W'(MAX_ARCS);
  localparam logic [5:0] VCOUNT_RESET = 6'd26;

  localparam logic [2:0] OP_ADD_VERTEX = 3'd0;
  localparam logic [2:0] OP_ADD_ARC    = 3'd1;
  localparam logic [2:0] OP_ADD_EDGE   = 3'd2;
  localparam logic [2:0] OP_BFS        = 3'd3;
  localparam logic [2:0] OP_DFS        = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [1:0] WHITE = 2'd0;
  localparam logic [1:0] GREY  = 2'd1;
  localparam logic [1:0] BLACK = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_EDGE2,
    S_VISIT,
    S_ARC_REQ,
    S_ARC_USE,
    S_FINISH
  } state_t;

endpackage

// ===== hdl/graph_bfs_dfs_traversal.sv =====
// graph traversal block: arc store, vertex tables and traversal sequencer; uses gbt_pkg
// add vertex / arc give one result after the start transfer, add edge gives two
// walks: a dispatch step, then S_VISIT per vertex, S_ARC_REQ and S_ARC_USE per arc walked
// and S_FINISH to close a vertex; arc reads use the one arc memory read port shared by the whole walk
// one command at a time, busy drops while the result with last set is out
// results cannot be stalled; rst (synchronous) empties the graph, vertex_count to 26
module graph_bfs_dfs_traversal (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  opcode,
  input  logic [5:0]                  from_vertex,
  input  logic [5:0]                  to_vertex,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [5:0]                  cfg_data,
  output logic                        strobe,
  output logic [gbt_pkg::VERTEX_W-1:0] vertex,
  output logic                        last,
  output logic [1:0]                  status
);
  import gbt_pkg::*;

  // sequencer and held command
  state_t state, state_next;
  logic [2:0] op;
  logic [5:0] fv, tv;
  logic [5:0] vcount;

  // vertex tables
  logic                 present [MAX_VERTICES];
  logic [ARC_PTR_W-1:0] head    [MAX_VERTICES];
  logic [1:0]           colour  [MAX_VERTICES];
  logic [VERTEX_W-1:0]  wl      [MAX_VERTICES];

  // arc store: target and next pointer in one word
  logic [ARC_WORD_W-1:0] arc_mem [MAX_ARCS];
  logic [ARC_WORD_W-1:0] rdata;
  logic [ARC_PTR_W-1:0]  arcs_used, arcs_used_next;

  // queue / stack pointers, walk state
  logic [LIVE_W-1:0]    rd, rd_next, wr, wr_next;
  logic [VERTEX_W-1:0]  cur, cur_next;
  logic [ARC_PTR_W-1:0] arc, arc_next;

  // result register inputs
  logic                 strobe_next, last_next;
  logic [VERTEX_W-1:0]  vertex_next;
  logic [1:0]           status_next;

  // table write controls
  logic                 pres_set, head_we, col_clr, col_we, wl_we, mem_we;
  logic [VERTEX_W-1:0]  pres_idx, head_idx, col_idx, wl_idx;
  logic [ARC_PTR_W-1:0] head_wd;
  logic [1:0]           col_wd;
  logic [VERTEX_W-1:0]  wl_wd;

  // shared helpers
  logic [LIVE_W-1:0]    live;
  logic [5:0]           arc_src, arc_dst;
  logic [1:0]           arc_st;
  logic [VERTEX_W-1:0]  top, bfs_v, tgt;
  logic [LIVE_W-1:0]    wr_dec;
  logic                 usable;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;

  // clamp the live index range
  assign live = (vcount > LIVE_W'(MAX_VERTICES)) ? LIVE_W'(MAX_VERTICES) : vcount;

  // the S_EDGE2 half of an edge swaps source and target
  assign arc_src = (state == S_EDGE2) ? tv : fv;
  assign arc_dst = (state == S_EDGE2) ? fv : tv;

  always_comb begin
    priority if (arc_src >= live || arc_dst >= live) begin
      arc_st = ST_RANGE;
    end else if (!present[arc_src[VERTEX_W-1:0]]) begin
      arc_st = ST_ABSENT;
    end else if (arcs_used >= ARC_PTR_W'(MAX_ARCS)) begin
      arc_st = ST_FULL;
    end else begin
      arc_st = ST_OK;
    end
  end

  assign wr_dec = wr - LIVE_W'(1);
  assign top    = wl[wr_dec[VERTEX_W-1:0]];
  assign bfs_v  = wl[rd[VERTEX_W-1:0]];
  assign tgt    = rdata[ARC_WORD_W-1:ARC_PTR_W];
  assign usable = (LIVE_W'(tgt) < live) && present[tgt] && (colour[tgt] == WHITE);

  always_comb begin
    state_next     = state;
    rd_next        = rd;
    wr_next        = wr;
    cur_next       = cur;
    arc_next       = arc;
    arcs_used_next = arcs_used;
    strobe_next    = 1'b0;
    vertex_next    = '0;
    last_next      = 1'b0;
    status_next    = ST_OK;
    pres_set       = 1'b0;
    pres_idx       = fv[VERTEX_W-1:0];
    head_we        = 1'b0;
    head_idx       = arc_src[VERTEX_W-1:0];
    head_wd        = NO_ARC;
    col_clr        = 1'b0;
    col_we         = 1'b0;
    col_idx        = cur;
    col_wd         = WHITE;
    wl_we          = 1'b0;
    wl_idx         = wr[VERTEX_W-1:0];
    wl_wd          = tgt;
    mem_we         = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        strobe_next = 1'b1;
        last_next   = 1'b1;
        state_next  = S_IDLE;
        unique case (op)
          OP_ADD_VERTEX: begin
            if (fv < live) begin
              pres_set = 1'b1;
              head_we  = 1'b1;
              head_idx = fv[VERTEX_W-1:0];
              head_wd  = NO_ARC;
            end else begin
              status_next = ST_RANGE;
            end
          end
          OP_ADD_ARC, OP_ADD_EDGE: begin
            status_next = arc_st;
            if (arc_st == ST_OK) begin
              mem_we         = 1'b1;
              head_we        = 1'b1;
              head_wd        = arcs_used;
              arcs_used_next = arcs_used + ARC_PTR_W'(1);
            end
            if (op == OP_ADD_EDGE) begin
              last_next  = 1'b0;
              state_next = S_EDGE2;
            end
          end
          OP_BFS, OP_DFS: begin
            if (fv >= live) begin
              status_next = ST_RANGE;
            end else if (!present[fv[VERTEX_W-1:0]]) begin
              status_next = ST_ABSENT;
            end else begin
              // fresh colours, start vertex seeds the work list
              strobe_next = 1'b0;
              last_next   = 1'b0;
              col_clr     = 1'b1;
              col_we      = 1'b1;
              col_idx     = fv[VERTEX_W-1:0];
              col_wd      = GREY;
              wl_we       = 1'b1;
              wl_idx      = '0;
              wl_wd       = fv[VERTEX_W-1:0];
              rd_next     = '0;
              wr_next     = LIVE_W'(1);
              state_next  = S_VISIT;
            end
          end
          default: begin
            status_next = ST_RANGE;
          end
        endcase
      end

      S_EDGE2: begin
        strobe_next = 1'b1;
        last_next   = 1'b1;
        status_next = arc_st;
        state_next  = S_IDLE;
        if (arc_st == ST_OK) begin
          mem_we         = 1'b1;
          head_we        = 1'b1;
          head_wd        = arcs_used;
          arcs_used_next = arcs_used + ARC_PTR_W'(1);
        end
      end

      S_VISIT: begin
        if (op == OP_BFS) begin
          cur_next   = bfs_v;
          rd_next    = rd + LIVE_W'(1);
          arc_next   = head[bfs_v];
          state_next = head[bfs_v][ARC_PTR_W-1] ? S_FINISH : S_ARC_REQ;
        end else if (colour[top] != BLACK && !head[top][ARC_PTR_W-1]) begin
          cur_next   = top;
          arc_next   = head[top];
          state_next = S_ARC_REQ;
        end else begin
          strobe_next = 1'b1;
          vertex_next = top;
          last_next   = (wr_dec == '0);
          wr_next     = wr_dec;
          state_next  = (wr_dec == '0) ? S_IDLE : S_VISIT;
        end
      end

      S_ARC_REQ: begin
        // memory read of arc lands in rdata
        state_next = S_ARC_USE;
      end

      S_ARC_USE: begin
        if (usable && wr < LIVE_W'(MAX_VERTICES)) begin
          col_we  = 1'b1;
          col_idx = tgt;
          col_wd  = GREY;
          wl_we   = 1'b1;
          wr_next = wr + LIVE_W'(1);
        end
        arc_next   = rdata[ARC_PTR_W-1:0];
        state_next = rdata[ARC_PTR_W-1] ? S_FINISH : S_ARC_REQ;
      end

      S_FINISH: begin
        col_we  = 1'b1;
        col_idx = cur;
        col_wd  = BLACK;
        if (op == OP_BFS) begin
          strobe_next = 1'b1;
          vertex_next = cur;
          last_next   = (rd == wr);
          state_next  = (rd == wr) ? S_IDLE : S_VISIT;
        end else begin
          state_next = S_VISIT;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcount    <= VCOUNT_RESET;
      arcs_used <= '0;
      strobe    <= 1'b0;
      rd        <= '0;
      wr        <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        present[i] <= 1'b0;
        head[i]    <= NO_ARC;
        colour[i]  <= WHITE;
      end
    end else begin
      state     <= state_next;
      arcs_used <= arcs_used_next;
      strobe    <= strobe_next;
      rd        <= rd_next;
      wr        <= wr_next;
      if (cfg_valid && cfg_ready) begin
        vcount <= cfg_data;
      end
      if (pres_set) begin
        present[pres_idx] <= 1'b1;
      end
      if (head_we) begin
        head[head_idx] <= head_wd;
      end
      // single write wins over the clear of all colours
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (col_we && col_idx == VERTEX_W'(i)) begin
          colour[i] <= col_wd;
        end else if (col_clr) begin
          colour[i] <= WHITE;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op <= opcode;
      fv <= from_vertex;
      tv <= to_vertex;
    end
    cur    <= cur_next;
    arc    <= arc_next;
    vertex <= vertex_next;
    last   <= last_next;
    status <= status_next;
    if (wl_we) begin
      wl[wl_idx] <= wl_wd;
    end
  end

  // arc memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      arc_mem[arcs_used[ARC_ADDR_W-1:0]] <= {arc_dst[VERTEX_W-1:0], head[arc_src[VERTEX_W-1:0]]};
    end
    rdata <= arc_mem[arc[ARC_ADDR_W-1:0]];
  end

endmodule

// ===== hdl/gbt_checker.sv =====
// port-level checker for the graph traversal block, bound to the top level
// depends on gbt_pkg and graph_bfs_dfs_traversal_assert.svh
`include "graph_bfs_dfs_traversal_assert.svh"

module gbt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         strobe,
  input logic                         last,
  input logic [gbt_pkg::VERTEX_W-1:0] vertex,
  input logic [1:0]                   status
);
  import gbt_pkg::*;

  // a command keeps the block busy
  `GBT_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  // the final result frees the block
  `GBT_ASSERT_NOW(a_last_idle, clk, rst, strobe && last, !busy)
  // more results follow while busy
  `GBT_ASSERT_NOW(a_more_busy, clk, rst, strobe && !last, busy)
  // error results carry vertex zero
  `GBT_ASSERT_NOW(a_err_vertex, clk, rst, strobe && status != ST_OK, vertex == '0)

endmodule

bind graph_bfs_dfs_traversal gbt_checker u_gbt_checker (.*);

// ===== test/graph_bfs_dfs_traversal_tb.sv =====
// self-checking testbench for the graph traversal block: graph building,
// breadth-first and depth-first walks, status codes, vertex_count settings
// depends on gbt_pkg and graph_bfs_dfs_traversal
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal_tb;
  import gbt_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] from_vertex;
    logic [5:0] to_vertex;
  } graph_cmd_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                last;
    logic [1:0]          status;
  } visit_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] opcode = '0;
  logic [5:0] from_vertex = '0;
  logic [5:0] to_vertex = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_data = '0;
  logic strobe;
  logic [VERTEX_W-1:0] vertex;
  logic last;
  logic [1:0] status;

  // busy as seen at the last rising edge, so the driver knows a transfer happened
  logic busy_at_edge = 1'b1;

  // sender idle percentage, changed between phases
  int unsigned send_idle_pct = 22;
  bit hold_sender = 1'b0;

  graph_cmd_t cmd_queue[$];
  visit_rec_t visit_expected[$];

  int unsigned error_count = 0;
  int unsigned cmds_sent = 0;
  int unsigned results_seen = 0;
  int unsigned traversals_sent = 0;
  int unsigned idle_cycles = 0;

  // predictor state
  logic [5:0]           p_vcount;
  bit                   p_present[MAX_VERTICES];
  int unsigned          p_head[MAX_VERTICES];
  int unsigned          p_target[MAX_ARCS];
  int unsigned          p_next[MAX_ARCS];
  int unsigned          p_arcs_used;
  logic [1:0]           p_colour[MAX_VERTICES];
  int unsigned          p_work[MAX_VERTICES];

  always #6 clk = ~clk;

  graph_bfs_dfs_traversal u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .from_vertex(from_vertex), .to_vertex(to_vertex),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .strobe(strobe), .vertex(vertex), .last(last), .status(status)
  );

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic int unsigned live_limit();
    return (p_vcount > MAX_VERTICES) ? MAX_VERTICES : int'(p_vcount);
  endfunction

  function automatic void graph_clear();
    p_vcount = VCOUNT_RESET;
    p_arcs_used = 0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      p_present[i] = 1'b0;
      p_head[i] = MAX_ARCS;
      p_colour[i] = WHITE;
    end
  endfunction

  function automatic void push_visit(input int unsigned v, input logic [1:0] st);
    visit_rec_t r;
    r.vertex = v[VERTEX_W-1:0];
    r.last = 1'b0;
    r.status = st;
    visit_expected.push_back(r);
  endfunction

  function automatic logic [1:0] link_arc(input int unsigned s, input int unsigned t);
    int unsigned n;
    n = live_limit();
    if (s >= n || t >= n) return ST_RANGE;
    if (!p_present[s]) return ST_ABSENT;
    if (p_arcs_used >= MAX_ARCS) return ST_FULL;
    p_target[p_arcs_used] = t;
    p_next[p_arcs_used] = p_head[s];
    p_head[s] = p_arcs_used;
    p_arcs_used++;
    return ST_OK;
  endfunction

  function automatic bit can_visit(input int unsigned t);
    return t < live_limit() && p_present[t] && p_colour[t] == WHITE;
  endfunction

  // walk the arc list of v, graying and appending white neighbours at fill
  function automatic void expand_arcs(input int unsigned v, inout int unsigned fill);
    int unsigned a;
    int unsigned t;
    a = p_head[v];
    while (a < MAX_ARCS) begin
      t = p_target[a];
      if (can_visit(t) && fill < MAX_VERTICES) begin
        p_colour[t] = GREY;
        p_work[fill++] = t;
      end
      a = p_next[a];
    end
  endfunction

  // appends the results that one command produces
  function automatic void predict_walk(input graph_cmd_t c);
    int unsigned n;
    int unsigned f;
    int unsigned t;
    int unsigned rd;
    int unsigned wr;
    int unsigned v;
    int unsigned base;
    visit_rec_t r;
    n = live_limit();
    f = c.from_vertex;
    t = c.to_vertex;
    base = visit_expected.size();
    case (c.opcode)
      OP_ADD_VERTEX: begin
        if (f < n) begin
          p_present[f] = 1'b1;
          p_head[f] = MAX_ARCS;
          push_visit(0, ST_OK);
        end else begin
          push_visit(0, ST_RANGE);
        end
      end
      OP_ADD_ARC: push_visit(0, link_arc(f, t));
      OP_ADD_EDGE: begin
        push_visit(0, link_arc(f, t));
        push_visit(0, link_arc(t, f));
      end
      OP_BFS, OP_DFS: begin
        if (f >= n) push_visit(0, ST_RANGE);
        else if (!p_present[f]) push_visit(0, ST_ABSENT);
        else begin
          for (int i = 0; i < MAX_VERTICES; i++) p_colour[i] = WHITE;
          p_colour[f] = GREY;
          p_work[0] = f;
          if (c.opcode == OP_BFS) begin
            rd = 0;
            wr = 1;
            while (rd < wr && rd < MAX_VERTICES) begin
              v = p_work[rd++];
              expand_arcs(v, wr);
              p_colour[v] = BLACK;
              push_visit(v, ST_OK);
            end
          end else begin
            // depth-first: emit on top when black or arc-less
            wr = 1;
            while (wr > 0) begin
              v = p_work[wr - 1];
              if (p_colour[v] != BLACK && p_head[v] < MAX_ARCS) begin
                expand_arcs(v, wr);
                p_colour[v] = BLACK;
              end else begin
                push_visit(v, ST_OK);
                wr--;
              end
            end
          end
          for (int i = 0; i < MAX_VERTICES; i++) p_colour[i] = WHITE;
        end
      end
      default: push_visit(0, ST_RANGE);
    endcase
    if (visit_expected.size() == base) push_visit(0, ST_OK);
    r = visit_expected[visit_expected.size() - 1];
    r.last = 1'b1;
    visit_expected[visit_expected.size() - 1] = r;
  endfunction

  // driver: one command per start transfer, random gaps at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      // previous edge took the command; pick the next one or drop start
      if (cmd_queue.size() > 0 && !hold_sender &&
          $urandom_range(99, 0) >= send_idle_pct) begin
        opcode <= cmd_queue[0].opcode;
        from_vertex <= cmd_queue[0].from_vertex;
        to_vertex <= cmd_queue[0].to_vertex;
        start <= 1'b1;
        void'(cmd_queue.pop_front());
      end else begin
        start <= 1'b0;
      end
    end else if (!start && cmd_queue.size() > 0 && !hold_sender &&
                 $urandom_range(99, 0) >= send_idle_pct) begin
      opcode <= cmd_queue[0].opcode;
      from_vertex <= cmd_queue[0].from_vertex;
      to_vertex <= cmd_queue[0].to_vertex;
      start <= 1'b1;
      void'(cmd_queue.pop_front());
    end
  end

  // monitor: predicts on each start transfer, checks each strobed result
  always @(posedge clk) begin
    visit_rec_t want;
    graph_cmd_t c;
    busy_at_edge <= rst ? 1'b1 : busy;
    if (!rst) begin
      if (start && !busy) begin
        c.opcode = opcode;
        c.from_vertex = from_vertex;
        c.to_vertex = to_vertex;
        predict_walk(c);
        cmds_sent++;
        if (opcode == OP_BFS || opcode == OP_DFS) traversals_sent++;
      end
      if (strobe) begin
        results_seen++;
        if (visit_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result vertex %0d", vertex));
        end else begin
          want = visit_expected.pop_front();
          if (vertex !== want.vertex)
            report_mismatch($sformatf("vertex %0d, want %0d", vertex, want.vertex));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", last, want.last));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        end
      end
      // watchdog on cycles with no transfer at all
      if ((start && !busy) || strobe || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", visit_expected.size());
        $display("** graph_bfs_dfs_traversal: FAILED **");
        $finish;
      end
    end
  end

  function automatic graph_cmd_t make_cmd(input logic [2:0] op, input int unsigned f,
                                          input int unsigned t);
    graph_cmd_t c;
    c.opcode = op;
    c.from_vertex = f[5:0];
    c.to_vertex = t[5:0];
    return c;
  endfunction

  // mostly in-range vertices, sometimes anything the field allows
  function automatic int unsigned pick_vertex(input int unsigned n);
    if (n > 0 && $urandom_range(99, 0) < 88) return $urandom_range(n - 1, 0);
    return $urandom_range(63, 0);
  endfunction

  task automatic wait_drained();
    while (cmd_queue.size() > 0 || start || busy || visit_expected.size() > 0)
      @(posedge clk);
    // a late add may still be in flight on the status path
    repeat (8) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [5:0] val);
    @(negedge clk);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    p_vcount = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random phase: a random mix of graph building and walking commands, with some noise
  task automatic random_phase(input int unsigned count);
    int unsigned n;
    int unsigned sel;
    n = live_limit();
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99, 0);
      if (sel < 22) cmd_queue.push_back(make_cmd(OP_ADD_VERTEX, pick_vertex(n), $urandom_range(63, 0)));
      else if (sel < 45) cmd_queue.push_back(make_cmd(OP_ADD_ARC, pick_vertex(n), pick_vertex(n)));
      else if (sel < 62) cmd_queue.push_back(make_cmd(OP_ADD_EDGE, pick_vertex(n), pick_vertex(n)));
      else if (sel < 78) cmd_queue.push_back(make_cmd(OP_BFS, pick_vertex(n), $urandom_range(63, 0)));
      else if (sel < 94) cmd_queue.push_back(make_cmd(OP_DFS, pick_vertex(n), $urandom_range(63, 0)));
      else cmd_queue.push_back(make_cmd(3'($urandom_range(7, 5)), $urandom_range(63, 0),
                                        $urandom_range(63, 0)));
    end
  endtask

  initial begin
    graph_clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: range and absent errors, every operation, small walk
    cmd_queue.push_back(make_cmd(OP_BFS, 0, 0));          // start absent
    cmd_queue.push_back(make_cmd(OP_DFS, 63, 0));         // start out of range
    cmd_queue.push_back(make_cmd(OP_ADD_VERTEX, 26, 0));  // just past the count
    cmd_queue.push_back(make_cmd(OP_ADD_ARC, 1, 2));      // source absent
    for (int v = 0; v < 5; v++) cmd_queue.push_back(make_cmd(OP_ADD_VERTEX, v, 63));
    cmd_queue.push_back(make_cmd(OP_ADD_VERTEX, 25, 0));
    cmd_queue.push_back(make_cmd(OP_ADD_ARC, 0, 63));     // target out of range
    cmd_queue.push_back(make_cmd(OP_ADD_ARC, 0, 1));
    cmd_queue.push_back(make_cmd(OP_ADD_ARC, 0, 20));     // target not present
    cmd_queue.push_back(make_cmd(OP_ADD_EDGE, 1, 2));
    cmd_queue.push_back(make_cmd(OP_ADD_EDGE, 3, 7));     // second half absent
    cmd_queue.push_back(make_cmd(OP_ADD_EDGE, 2, 25));
    cmd_queue.push_back(make_cmd(OP_ADD_ARC, 4, 4));      // self loop
    cmd_queue.push_back(make_cmd(OP_BFS, 0, 0));
    cmd_queue.push_back(make_cmd(OP_DFS, 0, 0));
    cmd_queue.push_back(make_cmd(OP_DFS, 4, 0));          // self loop only
    cmd_queue.push_back(make_cmd(OP_BFS, 3, 0));          // only an arc to an absent vertex
    cmd_queue.push_back(make_cmd(OP_ADD_VERTEX, 1, 0));   // re-add empties list
    cmd_queue.push_back(make_cmd(OP_BFS, 0, 0));
    cmd_queue.push_back(make_cmd(3'd5, 0, 0));
    cmd_queue.push_back(make_cmd(3'd7, 63, 63));
    wait_drained();

    random_phase(30);
    wait_drained();

    // pause the sender while commands queue up, then reverse idling
    hold_sender = 1'b1;
    random_phase(10);
    repeat (50) @(posedge clk);
    hold_sender = 1'b0;
    send_idle_pct = 85;
    wait_drained();

    // maximum count, then a small one, then zero, then oversized
    write_vertex_count(6'd32);
    random_phase(20);
    wait_drained();
    write_vertex_count(6'd1);
    cmd_queue.push_back(make_cmd(OP_ADD_VERTEX, 0, 0));
    cmd_queue.push_back(make_cmd(OP_ADD_ARC, 0, 0));
    cmd_queue.push_back(make_cmd(OP_DFS, 0, 0));
    cmd_queue.push_back(make_cmd(OP_BFS, 1, 0));
    wait_drained();
    write_vertex_count(6'd0);
    cmd_queue.push_back(make_cmd(OP_ADD_VERTEX, 0, 0));
    cmd_queue.push_back(make_cmd(OP_BFS, 0, 0));
    wait_drained();

    send_idle_pct = 0;
    write_vertex_count(6'd63);
    // dense graph to fill the arc store
    for (int i = 0; i < 32; i++) cmd_queue.push_back(make_cmd(OP_ADD_VERTEX, i, 0));
    for (int i = 0; i < 130; i++)
      cmd_queue.push_back(make_cmd(OP_ADD_EDGE, $urandom_range(31, 0), $urandom_range(31, 0)));
    cmd_queue.push_back(make_cmd(OP_BFS, 0, 0));
    cmd_queue.push_back(make_cmd(OP_DFS, 31, 0));
    random_phase(10);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("ran %0d commands (%0d walks), checked %0d results",
             cmds_sent, traversals_sent, results_seen);
    $display("vertex_count settings 26, 32, 1, 0 and 63; arc store filled to %0d",
             p_arcs_used);
    if (error_count == 0 && visit_expected.size() == 0) begin
      $display("** graph_bfs_dfs_traversal: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, visit_expected.size());
      $display("** graph_bfs_dfs_traversal: FAILED **");
    end
    $finish;
  end

endmodule

// ===== graph_bfs_dfs_traversal.f =====
+incdir+hdl
hdl/gbt_pkg.sv
hdl/graph_bfs_dfs_traversal.sv
hdl/gbt_checker.sv
test/graph_bfs_dfs_traversal_tb.sv
